// ===== design/particle_box_bounce_obstacle_cull_unit_assert.svh =====
// Assertion macros shared by the particle cull unit.
`ifndef PARTICLE_BOX_BOUNCE_OBSTACLE_CULL_UNIT_ASSERT_SVH
`define PARTICLE_BOX_BOUNCE_OBSTACLE_CULL_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define PB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== design/pbboc_pkg.sv =====
// Shared types and constants of the particle cull unit.
package pbboc_pkg;
  localparam int unsigned MaxObstacles = 4;
  localparam int unsigned PlanesPerObstacle = 6;
  localparam logic [31:0] PosDead = 32'h7FFF_FFFF;
  localparam logic [30:0] TimeStepReset = 31'd65536;
  localparam logic [31:0] RoomMinReset = 32'hFFF6_0000;
  localparam logic [31:0] RoomMaxReset = 32'h000A_0000;

  localparam logic [2:0] RegTimeStep = 3'd0;
  localparam logic [2:0] RegMinX = 3'd1;
  localparam logic [2:0] RegMinY = 3'd2;
  localparam logic [2:0] RegMinZ = 3'd3;
  localparam logic [2:0] RegMaxX = 3'd4;
  localparam logic [2:0] RegMaxY = 3'd5;
  localparam logic [2:0] RegMaxZ = 3'd6;
  localparam logic [2:0] RegObstacles = 3'd7;

  typedef enum logic [2:0] {
    StIdle, StScale, StCheck, StRead, StDot, StMove, StOut
  } state_e;

  // One plane: point then normal, three axes each.
  typedef struct packed {
    logic signed [31:0] px, py, pz, nx, ny, nz;
  } plane_t;

  // Control between the sequencer and the datapath.
  typedef struct packed {
    logic       load_in;
    logic [1:0] axis;
    logic       scale_q;
    logic       scale_step;
    logic       flip;
    logic       clear_acc;
    logic       dot_step;
  } dp_ctrl_t;
endpackage

// ===== design/pbboc_ram.sv =====
// Generic single-port write, registered-read RAM.
module pbboc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/pbboc_mac.sv =====
// Shared 33x33 signed multiplier with a registered product and a 68-bit accumulator.
module pbboc_mac (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  input  logic               clear_i,
  input  logic               acc_en_i,
  output logic signed [65:0] prod_o,
  output logic signed [67:0] acc_o
);
  logic signed [65:0] prod_q;
  logic signed [67:0] acc_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
    if (clear_i) begin
      acc_q <= '0;
    end else if (acc_en_i) begin
      acc_q <= acc_q + 68'(prod_q);
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;
endmodule

// ===== design/particle_box_bounce_obstacle_cull_unit.sv =====
// Particle step, room bounce and obstacle cull: sequencer, plane store and datapath.
//
// Input channel in_valid_i/in_stall_o carries one request; func_i = 1 loads one
// obstacle plane, func_i = 0 steps one particle. Output channel out_valid_o /
// out_stall_i returns one result per step request; loads return nothing.
// Configuration registers are written through cfg_we_i, cfg_index_i, cfg_data_i
// and must only change while the block is idle.
// One shared multiplier does every product: v*dt per axis and, per plane, three
// products of the point offset and the normal that are summed in an accumulator.
// A load is written into the plane store and the next request may follow at once.
// A step checks the room after a first scale pass. When the point is inside and
// obstacles are enabled, the planes of each obstacle are read in turn and a dot
// product taken for each; an obstacle that kills ends the test. A second scale
// pass gives the final position; the next request is taken once it is registered.
// in_stall_o is high while a step is in work. A result is held in the output
// registers until out_stall_i is low; a later step waits at its end for that.
// Reset returns the configuration registers to their default values and the sequencer
// to idle; the plane store is not cleared and must be written before it is used.
module particle_box_bounce_obstacle_cull_unit #(
  parameter int unsigned MaxObstacles = pbboc_pkg::MaxObstacles
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [1:0]         obstacle_index_i,
  input  logic [2:0]         plane_index_i,
  input  logic signed [31:0] normal_x_i,
  input  logic signed [31:0] normal_y_i,
  input  logic signed [31:0] normal_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] new_pos_x_o,
  output logic signed [31:0] new_pos_y_o,
  output logic signed [31:0] new_pos_z_o,
  output logic signed [31:0] new_vel_x_o,
  output logic signed [31:0] new_vel_y_o,
  output logic signed [31:0] new_vel_z_o,
  output logic               dead_o
);
  `include "particle_box_bounce_obstacle_cull_unit_assert.svh"

  localparam int unsigned Planes = MaxObstacles * pbboc_pkg::PlanesPerObstacle;
  localparam int unsigned AddrW = $clog2(Planes);
  localparam int unsigned ObW = $clog2(MaxObstacles + 1);
  localparam int unsigned PlaneW = $bits(pbboc_pkg::plane_t);

  // Configuration.
  logic [30:0]        time_step_q;
  logic signed [31:0] room_min_q [3];
  logic signed [31:0] room_max_q [3];
  logic [2:0]         obst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_step_q <= pbboc_pkg::TimeStepReset;
      for (int i = 0; i < 3; i++) begin
        room_min_q[i] <= pbboc_pkg::RoomMinReset;
        room_max_q[i] <= pbboc_pkg::RoomMaxReset;
      end
      obst_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pbboc_pkg::RegTimeStep:  time_step_q <= cfg_data_i[30:0];
        pbboc_pkg::RegMinX:      room_min_q[0] <= cfg_data_i;
        pbboc_pkg::RegMinY:      room_min_q[1] <= cfg_data_i;
        pbboc_pkg::RegMinZ:      room_min_q[2] <= cfg_data_i;
        pbboc_pkg::RegMaxX:      room_max_q[0] <= cfg_data_i;
        pbboc_pkg::RegMaxY:      room_max_q[1] <= cfg_data_i;
        pbboc_pkg::RegMaxZ:      room_max_q[2] <= cfg_data_i;
        pbboc_pkg::RegObstacles: obst_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  logic [ObW-1:0] n_obst;
  always_comb begin
    if (32'(obst_q) > MaxObstacles) n_obst = ObW'(MaxObstacles);
    else n_obst = ObW'(obst_q);
  end

  // Plane store.
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr, ram_raddr;
  pbboc_pkg::plane_t      ram_wdata, plane_rd;
  logic [PlaneW-1:0]      ram_rdata;
  logic                   in_acc;

  assign in_acc = in_valid_i && !in_stall_o;
  assign ram_we = in_acc && func_i && (32'(obstacle_index_i) < MaxObstacles)
                  && (plane_index_i < 3'(pbboc_pkg::PlanesPerObstacle));
  assign ram_waddr = AddrW'(32'(obstacle_index_i) * pbboc_pkg::PlanesPerObstacle
                            + 32'(plane_index_i));
  assign ram_wdata = '{pos_x_i, pos_y_i, pos_z_i, normal_x_i, normal_y_i, normal_z_i};
  assign plane_rd = pbboc_pkg::plane_t'(ram_rdata);

  pbboc_ram #(.Width(PlaneW), .Depth(Planes)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(PlaneW'(ram_wdata)),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  // Sequencer state.
  pbboc_pkg::state_e state_q, state_d;
  logic [1:0]        axis_q, axis_d;      // axis, or dot term
  logic [1:0]        phase_q, phase_d;    // 0 issue, 1 product ready, 2 consume
  logic              second_q, second_d;  // second scale pass (final move)
  logic [AddrW-1:0]  plane_q, plane_d;
  logic [ObW-1:0]    obj_q, obj_d;
  logic [2:0]        pl_q, pl_d;
  logic              all_neg_q, all_neg_d;
  logic              out_valid_q;

  logic signed [31:0] p_q [3];
  logic signed [31:0] v_q [3];
  logic signed [50:0] q_q [3];
  logic               dead_q;
  logic signed [31:0] np_q [3];

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic signed [67:0] acc;
  logic               mac_clear, mac_acc;

  pbboc_mac u_mac (
    .clk_i, .a_i(mul_a), .b_i(mul_b), .clear_i(mac_clear), .acc_en_i(mac_acc),
    .prod_o(prod), .acc_o(acc)
  );

  // In the dot loop the point is inside the room, so each offset fits 33 bits.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == pbboc_pkg::StDot) begin
      case (axis_q)
        2'd0: begin
          mul_a = 33'(q_q[0] - 51'(plane_rd.px));
          mul_b = 33'(plane_rd.nx);
        end
        2'd1: begin
          mul_a = 33'(q_q[1] - 51'(plane_rd.py));
          mul_b = 33'(plane_rd.ny);
        end
        default: begin
          mul_a = 33'(q_q[2] - 51'(plane_rd.pz));
          mul_b = 33'(plane_rd.nz);
        end
      endcase
    end else begin
      mul_a = 33'(v_q[axis_q]);
      mul_b = {2'b00, time_step_q};
    end
  end

  // Floor shift of the product; an arithmetic shift rounds toward minus infinity.
  logic signed [49:0] scaled;
  logic signed [50:0] sum_s;
  assign scaled = 50'(prod >>> 16);
  assign sum_s  = 51'(p_q[axis_q]) + 51'(scaled);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbboc_pkg::StIdle:
        if (in_acc && !func_i) state_d = pbboc_pkg::StScale;
      pbboc_pkg::StScale:
        if (phase_q == 2'd2 && axis_q == 2'd2) begin
          state_d = second_q ? pbboc_pkg::StOut : pbboc_pkg::StCheck;
        end
      pbboc_pkg::StCheck: state_d = pbboc_pkg::StRead;
      pbboc_pkg::StRead:  state_d = pbboc_pkg::StDot;
      pbboc_pkg::StDot:
        if (phase_q == 2'd2 && axis_q == 2'd2) state_d = pbboc_pkg::StMove;
      pbboc_pkg::StMove:  state_d = pbboc_pkg::StScale;
      pbboc_pkg::StOut:   if (!out_valid_q || !out_stall_i) state_d = pbboc_pkg::StIdle;
      default: state_d = pbboc_pkg::StIdle;
    endcase
  end

  logic in_room, in_ax [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      in_ax[i] = (q_q[i] < 51'(room_max_q[i])) && (q_q[i] > 51'(room_min_q[i]));
    end
    in_room = in_ax[0] && in_ax[1] && in_ax[2];
  end

  // Sequencer counters and data registers.
  logic last_pl, obj_kill, plane_neg;
  assign last_pl = (pl_q == 3'(pbboc_pkg::PlanesPerObstacle - 1));
  assign plane_neg = all_neg_q && acc[67];
  assign obj_kill = plane_neg && last_pl;

  always_comb begin
    axis_d = axis_q;
    phase_d = phase_q;
    second_d = second_q;
    plane_d = plane_q;
    obj_d = obj_q;
    pl_d = pl_q;
    all_neg_d = all_neg_q;
    mac_clear = 1'b0;
    mac_acc = 1'b0;
    ram_raddr = plane_q;
    case (state_q)
      pbboc_pkg::StIdle: begin
        axis_d = '0;
        phase_d = '0;
        second_d = 1'b0;
      end
      pbboc_pkg::StScale: begin
        if (phase_q == 2'd2) begin
          phase_d = '0;
          axis_d = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        end else begin
          phase_d = phase_q + 2'd1;
        end
        plane_d = '0;
        obj_d = '0;
        pl_d = '0;
        all_neg_d = 1'b1;
      end
      pbboc_pkg::StRead: begin
        mac_clear = 1'b1;
        axis_d = '0;
        phase_d = '0;
      end
      pbboc_pkg::StDot: begin
        // Each term: operands in, product registered, then accumulated.
        if (phase_q == 2'd1) mac_acc = 1'b1;
        if (phase_q == 2'd2) begin
          phase_d = '0;
          axis_d = (axis_q == 2'd2) ? 2'd0 : axis_q + 2'd1;
        end else begin
          phase_d = phase_q + 2'd1;
        end
      end
      pbboc_pkg::StMove: begin
        // A new obstacle starts with every plane still counted as negative.
        all_neg_d = last_pl ? 1'b1 : plane_neg;
        plane_d = plane_q + AddrW'(1);
        ram_raddr = plane_q + AddrW'(1);
        if (last_pl) begin
          pl_d = '0;
          obj_d = obj_q + ObW'(1);
        end else begin
          pl_d = pl_q + 3'd1;
        end
        second_d = 1'b1;
      end
      default: ;
    endcase
  end

  // The dot loop is entered from the check only when inside the room with
  // obstacles left; StMove chooses between another plane and the final move.
  pbboc_pkg::state_e state_n;
  logic more;
  assign more = !obj_kill && !(last_pl && (obj_q + ObW'(1) >= n_obst));
  always_comb begin
    state_n = state_d;
    if (state_q == pbboc_pkg::StCheck) begin
      if (!in_room || n_obst == '0) state_n = pbboc_pkg::StScale;
      else state_n = pbboc_pkg::StRead;
    end else if (state_q == pbboc_pkg::StMove && more) begin
      state_n = pbboc_pkg::StRead;
    end
  end

  logic second_n;
  assign second_n = (state_q == pbboc_pkg::StCheck) ? 1'b1 :
                    (state_q == pbboc_pkg::StMove) ? !more : second_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbboc_pkg::StIdle;
      axis_q <= '0;
      phase_q <= '0;
      second_q <= 1'b0;
      plane_q <= '0;
      obj_q <= '0;
      pl_q <= '0;
      all_neg_q <= 1'b1;
      out_valid_q <= 1'b0;
      dead_q <= 1'b0;
    end else begin
      state_q <= state_n;
      axis_q <= axis_d;
      phase_q <= phase_d;
      second_q <= second_n;
      plane_q <= plane_d;
      obj_q <= obj_d;
      pl_q <= pl_d;
      all_neg_q <= all_neg_d;
      if (state_q == pbboc_pkg::StIdle && in_acc && !func_i) dead_q <= 1'b0;
      if (state_q == pbboc_pkg::StMove && obj_kill) dead_q <= 1'b1;
      if (state_q == pbboc_pkg::StOut && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == pbboc_pkg::StIdle && in_acc && !func_i) begin
      p_q <= '{pos_x_i, pos_y_i, pos_z_i};
      v_q <= '{vel_x_i, vel_y_i, vel_z_i};
    end
    if (state_q == pbboc_pkg::StScale && phase_q == 2'd2) begin
      if (second_q) begin
        if (sum_s > 51'sd2147483647) np_q[axis_q] <= 32'h7FFF_FFFF;
        else if (sum_s < -51'sd2147483648) np_q[axis_q] <= 32'h8000_0000;
        else np_q[axis_q] <= sum_s[31:0];
      end else begin
        q_q[axis_q] <= sum_s;
      end
    end
    if (state_q == pbboc_pkg::StCheck && !in_room) begin
      for (int i = 0; i < 3; i++) begin
        if (q_q[i] < 51'(room_min_q[i]) || q_q[i] > 51'(room_max_q[i])) begin
          v_q[i] <= (v_q[i] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v_q[i];
        end
      end
    end
    if (state_q == pbboc_pkg::StMove && obj_kill) begin
      p_q <= '{pbboc_pkg::PosDead, pbboc_pkg::PosDead, pbboc_pkg::PosDead};
      v_q <= '{32'sd0, 32'sd0, 32'sd0};
    end
    if (state_q == pbboc_pkg::StOut && (!out_valid_q || !out_stall_i)) begin
      new_pos_x_o <= np_q[0];
      new_pos_y_o <= np_q[1];
      new_pos_z_o <= np_q[2];
      new_vel_x_o <= v_q[0];
      new_vel_y_o <= v_q[1];
      new_vel_z_o <= v_q[2];
      dead_o <= dead_q;
    end
  end

  assign in_stall_o  = (state_q != pbboc_pkg::StIdle);
  assign out_valid_o = out_valid_q;

  `PB_ASSERT_IMP(a_busy_stall, clk_i, rst_ni, state_q != pbboc_pkg::StIdle, in_stall_o)
  `PB_ASSERT_NEXT(a_hold_out, clk_i, rst_ni, out_valid_q && out_stall_i, out_valid_q)
  `PB_ASSERT_IMP(a_obj_range, clk_i, rst_ni, state_q == pbboc_pkg::StDot,
                 obj_q < n_obst)
  `PB_ASSERT_NEXT(a_load_idle, clk_i, rst_ni, in_acc && func_i,
                  state_q == pbboc_pkg::StIdle)
endmodule

// ===== test/particle_box_bounce_obstacle_cull_unit_test.sv =====
// Self-checking testbench for the particle step, room bounce and obstacle cull unit.
`timescale 1ns / 1ps

module particle_box_bounce_obstacle_cull_unit_test;

  localparam int unsigned NumPlanes =
    pbboc_pkg::MaxObstacles * pbboc_pkg::PlanesPerObstacle;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic               func;
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [1:0]         ob;
    logic [2:0]         pl;
    logic signed [31:0] nx, ny, nz;
  } particle_req_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic               dead;
  } particle_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = pbboc_pkg::RegTimeStep;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  particle_req_t cur_req = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] got_px, got_py, got_pz, got_vx, got_vy, got_vz;
  logic got_dead;
  particle_res_t got;

  assign got = {got_px, got_py, got_pz, got_vx, got_vy, got_vz, got_dead};

  particle_box_bounce_obstacle_cull_unit uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .func_i(cur_req.func),
    .pos_x_i(cur_req.px), .pos_y_i(cur_req.py), .pos_z_i(cur_req.pz),
    .vel_x_i(cur_req.vx), .vel_y_i(cur_req.vy), .vel_z_i(cur_req.vz),
    .obstacle_index_i(cur_req.ob), .plane_index_i(cur_req.pl),
    .normal_x_i(cur_req.nx), .normal_y_i(cur_req.ny), .normal_z_i(cur_req.nz),
    .out_valid_o, .out_stall_i,
    .new_pos_x_o(got_px), .new_pos_y_o(got_py), .new_pos_z_o(got_pz),
    .new_vel_x_o(got_vx), .new_vel_y_o(got_vy), .new_vel_z_o(got_vz),
    .dead_o(got_dead)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the configuration and plane store.
  logic [30:0] sh_dt = pbboc_pkg::TimeStepReset;
  logic signed [31:0] sh_min [3];
  logic signed [31:0] sh_max [3];
  logic [2:0] sh_obstacles = '0;
  logic signed [31:0] pl_pt [NumPlanes][3];
  logic signed [31:0] pl_nrm [NumPlanes][3];

  // Box obstacles as placed by the stimulus, used to aim particles at them.
  logic signed [31:0] box_c [pbboc_pkg::MaxObstacles][3];

  particle_req_t pending_reqs [$];
  particle_res_t expected_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int idle_cycles = 0;

  function automatic longint dt_scale(logic signed [31:0] v);
    longint prod;
    prod = longint'(v) * longint'(sh_dt);
    return prod >>> 16;
  endfunction

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic plane_below(int e, longint q [3]);
    logic signed [127:0] acc, d, n;
    acc = '0;
    for (int a = 0; a < 3; a++) begin
      d = q[a] - longint'(pl_pt[e][a]);
      n = pl_nrm[e][a];
      acc = acc + d * n;
    end
    return acc < 0;
  endfunction

  // Applies a request to the shadow state; returns 1 when it produces a result.
  function automatic bit predict_step(particle_req_t r, output particle_res_t res);
    logic signed [31:0] p [3];
    logic signed [31:0] v [3];
    longint q [3];
    logic in_room, dead, all_neg;
    int n;
    p = '{r.px, r.py, r.pz};
    v = '{r.vx, r.vy, r.vz};
    res = '0;
    if (r.func) begin
      if (r.pl < pbboc_pkg::PlanesPerObstacle) begin
        pl_pt[r.ob * pbboc_pkg::PlanesPerObstacle + r.pl] = p;
        pl_nrm[r.ob * pbboc_pkg::PlanesPerObstacle + r.pl] = '{r.nx, r.ny, r.nz};
      end
      return 0;
    end
    in_room = 1'b1;
    dead = 1'b0;
    for (int a = 0; a < 3; a++) begin
      q[a] = longint'(p[a]) + dt_scale(v[a]);
      if (!(q[a] < longint'(sh_max[a]) && q[a] > longint'(sh_min[a]))) in_room = 1'b0;
    end
    if (!in_room) begin
      for (int a = 0; a < 3; a++)
        if (q[a] < longint'(sh_min[a]) || q[a] > longint'(sh_max[a]))
          v[a] = (v[a] == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v[a];
    end else begin
      n = (sh_obstacles > pbboc_pkg::MaxObstacles) ? pbboc_pkg::MaxObstacles
                                                    : sh_obstacles;
      for (int j = 0; j < n && !dead; j++) begin
        all_neg = 1'b1;
        for (int k = 0; k < pbboc_pkg::PlanesPerObstacle; k++)
          if (!plane_below(j * pbboc_pkg::PlanesPerObstacle + k, q)) all_neg = 1'b0;
        dead = all_neg;
      end
      if (dead)
        for (int a = 0; a < 3; a++) begin
          p[a] = pbboc_pkg::PosDead;
          v[a] = '0;
        end
    end
    res.px = sat32(longint'(p[0]) + dt_scale(v[0]));
    res.py = sat32(longint'(p[1]) + dt_scale(v[1]));
    res.pz = sat32(longint'(p[2]) + dt_scale(v[2]));
    res.vx = v[0];
    res.vy = v[1];
    res.vz = v[2];
    res.dead = dead;
    return 1;
  endfunction

  // Driver: predicts each accepted request, then presents the next one.
  always @(posedge clk_i) begin
    particle_res_t res;
    logic accepted;
    accepted = in_valid_i && !in_stall_o;
    if (accepted) begin
      if (predict_step(cur_req, res)) expected_results.insert(expected_results.size(), res);
    end
    if (!in_valid_i || accepted) begin
      if (rst_ni && pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        cur_req <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor and watchdog.
  always @(posedge clk_i) begin
    particle_res_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        exp_res = expected_results.pop_front();
        if (got !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result differs: expected pos %h %h %h vel %h %h %h dead %b,",
                      " got pos %h %h %h vel %h %h %h dead %b"},
                     exp_res.px, exp_res.py, exp_res.pz, exp_res.vx, exp_res.vy,
                     exp_res.vz, exp_res.dead, got.px, got.py, got.pz, got.vx,
                     got.vy, got.vz, got.dead);
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("particle_box_bounce_obstacle_cull_unit: mismatch");
      $finish;
    end
  end

  task automatic add_req(particle_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      pbboc_pkg::RegTimeStep: sh_dt = data[30:0];
      pbboc_pkg::RegMinX, pbboc_pkg::RegMinY, pbboc_pkg::RegMinZ:
        sh_min[idx - pbboc_pkg::RegMinX] = data;
      pbboc_pkg::RegMaxX, pbboc_pkg::RegMaxY, pbboc_pkg::RegMaxZ:
        sh_max[idx - pbboc_pkg::RegMaxX] = data;
      default: sh_obstacles = data[2:0];
    endcase
  endtask

  task automatic configure(logic [31:0] dt, logic [31:0] lo, logic [31:0] hi,
                           logic [2:0] obstacles);
    write_reg(pbboc_pkg::RegTimeStep, dt);
    write_reg(pbboc_pkg::RegMinX, lo);
    write_reg(pbboc_pkg::RegMinY, lo);
    write_reg(pbboc_pkg::RegMinZ, lo);
    write_reg(pbboc_pkg::RegMaxX, hi);
    write_reg(pbboc_pkg::RegMaxY, hi);
    write_reg(pbboc_pkg::RegMaxZ, hi);
    write_reg(pbboc_pkg::RegObstacles, obstacles);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every request went in and every result came out.
  task automatic drain;
    while (pending_reqs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic particle_req_t step_req(logic signed [31:0] px, py, pz, vx, vy, vz);
    particle_req_t r;
    r = '0;
    r.px = px; r.py = py; r.pz = pz;
    r.vx = vx; r.vy = vy; r.vz = vz;
    r.ob = $urandom;
    r.pl = $urandom;
    r.nx = $urandom; r.ny = $urandom; r.nz = $urandom;
    return r;
  endfunction

  // Queues the six planes of an axis-aligned box around a random center.
  task automatic place_box(int j);
    particle_req_t r;
    logic signed [31:0] half, mag;
    half = $urandom_range(200000, 20000);
    for (int a = 0; a < 3; a++) box_c[j][a] = $signed($urandom_range(800000)) - 400000;
    for (int k = 0; k < pbboc_pkg::PlanesPerObstacle; k++) begin
      r = '0;
      r.func = 1'b1;
      r.ob = j;
      r.pl = k;
      r.vx = $urandom; r.vy = $urandom; r.vz = $urandom;
      mag = $urandom_range(1 << 20, 1);
      if (k % 2) mag = -mag;
      r.px = box_c[j][0]; r.py = box_c[j][1]; r.pz = box_c[j][2];
      case (k / 2)
        0: begin r.px = box_c[j][0] - (mag > 0 ? half : -half); r.nx = -mag; end
        1: begin r.py = box_c[j][1] - (mag > 0 ? half : -half); r.ny = -mag; end
        default: begin r.pz = box_c[j][2] - (mag > 0 ? half : -half); r.nz = -mag; end
      endcase
      add_req(r);
    end
  endtask

  function automatic logic signed [31:0] pick_between(longint lo, longint hi);
    longint span;
    if (hi <= lo) return $urandom;
    span = hi - lo;
    return lo + longint'({$urandom, $urandom} % 64'(span + 1));
  endfunction

  task automatic random_phase(int count);
    particle_req_t r;
    int sel, j;
    logic signed [31:0] vmax;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      vmax = 1 << $urandom_range(20, 4);
      if (sel < 5) begin
        place_box($urandom_range(pbboc_pkg::MaxObstacles - 1));
        continue;
      end else if (sel < 10) begin
        r = step_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        r.func = 1'b1;
      end else if (sel < 45) begin
        j = $urandom_range(pbboc_pkg::MaxObstacles - 1);
        r = step_req(box_c[j][0] + $signed($urandom_range(400000)) - 200000,
                     box_c[j][1] + $signed($urandom_range(400000)) - 200000,
                     box_c[j][2] + $signed($urandom_range(400000)) - 200000,
                     $signed($urandom_range(2 * vmax)) - vmax,
                     $signed($urandom_range(2 * vmax)) - vmax,
                     $signed($urandom_range(2 * vmax)) - vmax);
      end else if (sel < 75) begin
        r = step_req(pick_between(sh_min[0], sh_max[0]), pick_between(sh_min[1], sh_max[1]),
                     pick_between(sh_min[2], sh_max[2]),
                     $signed($urandom_range(2 * vmax)) - vmax,
                     $signed($urandom_range(2 * vmax)) - vmax,
                     $signed($urandom_range(2 * vmax)) - vmax);
      end else if (sel < 85) begin
        // Sitting on or right next to a wall.
        r = step_req(($urandom_range(1) ? sh_min[0] : sh_max[0]) + $signed($urandom_range(2)) - 1,
                     ($urandom_range(1) ? sh_min[1] : sh_max[1]) + $signed($urandom_range(2)) - 1,
                     ($urandom_range(1) ? sh_min[2] : sh_max[2]) + $signed($urandom_range(2)) - 1,
                     $signed($urandom_range(2)) - 1, $signed($urandom_range(2)) - 1,
                     $signed($urandom_range(2)) - 1);
      end else begin
        r = step_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
      add_req(r);
    end
  endtask

  initial begin
    particle_req_t r;
    sh_min = '{pbboc_pkg::RoomMinReset, pbboc_pkg::RoomMinReset, pbboc_pkg::RoomMinReset};
    sh_max = '{pbboc_pkg::RoomMaxReset, pbboc_pkg::RoomMaxReset, pbboc_pkg::RoomMaxReset};
    send_idle_pct = 10;
    recv_stall_pct = 70;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every plane gets written before any obstacle is enabled.
    for (int j = 0; j < pbboc_pkg::MaxObstacles; j++) place_box(j);
    r = step_req(1, 2, 3, 4, 5, 6);
    r.func = 1'b1;
    r.pl = 3'd6;
    r.ob = 2'd3;
    add_req(r);
    r.pl = 3'd7;
    add_req(r);
    add_req(step_req(0, 0, 0, 0, 0, 0));
    add_req(step_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    add_req(step_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    add_req(step_req(pbboc_pkg::RoomMaxReset, 0, 0, 0, 0, 0));
    add_req(step_req(0, pbboc_pkg::RoomMinReset, 0, 0, 0, 0));
    add_req(step_req(pbboc_pkg::RoomMaxReset + 1, 0, pbboc_pkg::RoomMinReset - 1,
                     -5, 7, 9));
    drain();

    configure(32'd65536, pbboc_pkg::RoomMinReset, pbboc_pkg::RoomMaxReset, 3'd4);
    for (int j = 0; j < pbboc_pkg::MaxObstacles; j++)
      add_req(step_req(box_c[j][0], box_c[j][1], box_c[j][2], 0, 0, 0));
    add_req(step_req(box_c[0][0] + 300000, box_c[0][1], box_c[0][2], 0, 0, 0));
    random_phase(250);
    drain();

    configure(32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 3'd7);
    random_phase(250);
    drain();

    send_idle_pct = 70;
    recv_stall_pct = 10;
    configure(32'h7FFF_FFFF, pbboc_pkg::RoomMinReset, pbboc_pkg::RoomMaxReset, 3'd2);
    random_phase(250);
    drain();

    configure($urandom, -$signed($urandom_range(900000, 500000)),
              $urandom_range(900000, 500000), 3'd1);
    random_phase(250);
    drain();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 3'd5);
    random_phase(250);
    drain();

    configure(32'd4096, pbboc_pkg::RoomMinReset, pbboc_pkg::RoomMaxReset, 3'd3);
    random_phase(250);
    drain();

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("particle_box_bounce_obstacle_cull_unit: match");
    end else begin
      $display("particle_box_bounce_obstacle_cull_unit: mismatch");
    end
    $finish;
  end

endmodule
